[rtl/dhcp_opt_pkg.sv]
// Types and constants shared by the DHCP options stream parser.
package dhcp_opt_pkg;

  localparam int unsigned HEADER_BYTES = 236;
  localparam int unsigned PLEN_MAX     = 1023;

  localparam logic [7:0] TAG_PAD     = 8'd0;
  localparam logic [7:0] TAG_END     = 8'd255;
  localparam logic [7:0] OP_BOOT_REQ = 8'd1;
  localparam logic [7:0] SEARCH_RST  = 8'd53;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_COOKIE = 2'd1,
    ST_NOT_REQ    = 2'd2,
    ST_OVERRUN    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_COOKIE = 5'b00010,
    PH_TAG    = 5'b00100,
    PH_LEN    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'd99;
      2'd1:    val = 8'd130;
      2'd2:    val = 8'd83;
      default: val = 8'd99;
    endcase
    return val;
  endfunction

endpackage

[rtl/dhcp_option_stream_parser.sv]
// DHCP options area parser: cookie and op check, option walk and search.
//
// Channel  Direction  Handshake            Payload
// in_      slave      in_tvalid/in_tready  tdata: data_byte, request_op; tuser: first_of_options
// out_     master     out_tvalid/out_tready tdata: offset, length, first byte, packet length
// cfg_     slave      cfg_valid/cfg_ready  cfg_data: search_type
//
// One byte per cycle while no result is stalled; each request is held in the input register and its
// result, if any, is written into the output register as the request leaves it.
// Reset is synchronous and active low; search_type resets to 53.
// A stalled result holds the output register and the input register takes one more
// request before in_tready falls.
module dhcp_option_stream_parser
  import dhcp_opt_pkg::*;
#(
  parameter int unsigned OPTION_AREA_BYTES = 312
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] request_op
  input  logic        in_tuser,   // [0] first_of_options
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [8:0] option_offset, [16:9] option_length,
                                  // [24:17] option_first_byte, [34:25] packet_length
  output logic [2:0]  out_tuser,  // [1:0] status, [2] found
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned OFF_W = $clog2(OPTION_AREA_BYTES + 257);
  localparam int unsigned SUM_W = OFF_W + 2;

  logic             s1_valid_r;
  logic [7:0]       s1_byte_r;
  logic [7:0]       s1_op_r;
  logic             s1_first_r;
  logic             adv;

  logic [7:0]       search_r;
  phase_t           phase_r, phase_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [7:0]       skip_r, skip_nxt;
  logic             op_req_r, op_req_nxt;
  logic             match_r, match_nxt;
  logic [OFF_W-1:0] moff_r, moff_nxt;
  logic [7:0]       mlen_r, mlen_nxt;
  logic [7:0]       mfirst_r, mfirst_nxt;

  logic             emit;
  status_t          emit_status;
  logic [SUM_W-1:0] plen_sum;
  logic [9:0]       plen;

  logic             out_valid_r;
  logic [39:0]      out_data_r, out_data_nxt;
  logic [2:0]       out_user_r, out_user_nxt;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  assign plen_sum = SUM_W'(HEADER_BYTES) + SUM_W'(off_r) + SUM_W'(1);
  assign plen     = (plen_sum > SUM_W'(PLEN_MAX)) ? 10'(PLEN_MAX) : plen_sum[9:0];

  always_comb begin
    phase_nxt   = phase_r;
    off_nxt     = off_r;
    skip_nxt    = skip_r;
    op_req_nxt  = op_req_r;
    match_nxt   = match_r;
    moff_nxt    = moff_r;
    mlen_nxt    = mlen_r;
    mfirst_nxt  = mfirst_r;
    emit        = 1'b0;
    emit_status = ST_OK;
    if (s1_first_r) begin
      off_nxt    = '0;
      skip_nxt   = '0;
      match_nxt  = 1'b0;
      moff_nxt   = '0;
      mlen_nxt   = '0;
      mfirst_nxt = '0;
      op_req_nxt = (s1_op_r == OP_BOOT_REQ);
      if (s1_byte_r != cookie_byte(2'd0)) begin
        emit        = 1'b1;
        emit_status = ST_BAD_COOKIE;
        phase_nxt   = PH_IDLE;
      end else begin
        phase_nxt = PH_COOKIE;
        off_nxt   = OFF_W'(1);
      end
    end else begin
      unique case (phase_r)
        PH_COOKIE: begin
          if (s1_byte_r != cookie_byte(off_r[1:0])) begin
            emit        = 1'b1;
            emit_status = ST_BAD_COOKIE;
            phase_nxt   = PH_IDLE;
          end else if (off_r >= OFF_W'(3) && !op_req_r) begin
            emit        = 1'b1;
            emit_status = ST_NOT_REQ;
            phase_nxt   = PH_IDLE;
          end else begin
            if (off_r >= OFF_W'(3)) begin
              phase_nxt = PH_TAG;
            end
            off_nxt = off_r + OFF_W'(1);
          end
        end
        PH_TAG: begin
          if (off_r >= OFF_W'(OPTION_AREA_BYTES)) begin
            emit        = 1'b1;
            emit_status = ST_OVERRUN;
            phase_nxt   = PH_IDLE;
          end else if (s1_byte_r == TAG_END) begin
            emit        = 1'b1;
            emit_status = ST_OK;
            phase_nxt   = PH_IDLE;
          end else begin
            if (s1_byte_r != TAG_PAD) begin
              if (!match_r && s1_byte_r == search_r) begin
                match_nxt = 1'b1;
                moff_nxt  = off_r;
              end
              phase_nxt = PH_LEN;
            end
            off_nxt = off_r + OFF_W'(1);
          end
        end
        PH_LEN: begin
          if (match_r && (moff_r + OFF_W'(1)) == off_r) begin
            mlen_nxt = s1_byte_r;
          end
          if (s1_byte_r == 8'd0) begin
            phase_nxt = PH_TAG;
          end else begin
            skip_nxt  = s1_byte_r;
            phase_nxt = PH_DATA;
          end
          off_nxt = off_r + OFF_W'(1);
        end
        PH_DATA: begin
          if (match_r && (moff_r + OFF_W'(2)) == off_r) begin
            mfirst_nxt = s1_byte_r;
          end
          if (skip_r != 8'd0) begin
            skip_nxt = skip_r - 8'd1;
          end
          if (skip_r <= 8'd1) begin
            phase_nxt = PH_TAG;
          end
          off_nxt = off_r + OFF_W'(1);
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_user_nxt = {1'b0, emit_status};
    if (emit_status == ST_OK) begin
      out_data_nxt[34:25] = plen;
      if (match_r) begin
        out_user_nxt[2]     = 1'b1;
        out_data_nxt[8:0]   = moff_r[8:0];
        out_data_nxt[16:9]  = mlen_r;
        out_data_nxt[24:17] = mfirst_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      search_r    <= SEARCH_RST;
      phase_r     <= PH_IDLE;
      off_r       <= '0;
      skip_r      <= '0;
      op_req_r    <= 1'b0;
      match_r     <= 1'b0;
      moff_r      <= '0;
      mlen_r      <= '0;
      mfirst_r    <= '0;
    end else begin
      if (cfg_valid) begin
        search_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= emit;
        phase_r     <= phase_nxt;
        off_r       <= off_nxt;
        skip_r      <= skip_nxt;
        op_req_r    <= op_req_nxt;
        match_r     <= match_nxt;
        moff_r      <= moff_nxt;
        mlen_r      <= mlen_nxt;
        mfirst_r    <= mfirst_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_op_r    <= in_tdata[15:8];
      s1_first_r <= in_tuser;
    end
    if (adv && emit) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != ST_OK) |-> (out_tdata == '0 && !out_tuser[2]))
    else $error("error result carries nonzero fields");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tdata[24:0] == '0))
    else $error("result without match carries option fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_data_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (skip_r != 8'd0))
    else $error("data phase with no bytes left to skip");

endmodule
